// File: rtl/pica_pkg.sv
// Shared types and constants for the PI controller with integrator clamp.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps

package pica_pkg;

   // Field widths
   localparam int LEVEL_W  = 10;
   localparam int GAIN_W   = 8;
   localparam int DRIVE_W  = 7;
   localparam int ERR_W    = 6;   // magnitude of the limited error, 0..50
   localparam int P_MAG_W  = 14;  // |err| * prop_gain, up to 12750
   localparam int I_MAG_W  = 16;  // |err| * integ_gain * 3, up to 38250
   localparam int P_TERM_W = 12;  // signed, -1275..1275
   localparam int I_TERM_W = 13;  // signed, -3825..3825
   localparam int ACC_W    = 16;
   localparam int CSR_IDX_W = 4;

   // Controller constants
   localparam logic [ERR_W-1:0]   ERR_LIMIT  = 6'd50;
   localparam logic [DRIVE_W-1:0] OUT_MAX    = 7'd100;
   localparam logic [ACC_W-1:0]   ACC_RESET  = 16'd10;
   localparam logic [GAIN_W-1:0]  GAIN_RESET = 8'd2;

   // Unsigned divide by ten: (x * 0xCCCD) >> 19 is exact for any 16-bit x
   localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
   localparam int          DIV10_SHIFT = 19;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 4'd1;

   typedef struct packed {
      logic [LEVEL_W-1:0] target_level;
      logic [LEVEL_W-1:0] measured_level;
   } req_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] drive_level;
      logic               limited;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
   } gain_type;

   typedef struct packed {
      logic signed [P_TERM_W-1:0] p_term;
      logic signed [I_TERM_W-1:0] i_step;
   } term_type;

endpackage

// File: rtl/pica_csr.sv
// Gain registers of the PI controller, written through the csr_ port.
// Depends on pica_pkg.
`timescale 1ns / 1ps

module pica_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pica_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pica_pkg::GAIN_W-1:0]        csr_wdata,
   output pica_pkg::gain_type                 gains
);

   pica_pkg::gain_type gains_ff;
   pica_pkg::gain_type gains_in;

   // Always take a write beat
   assign csr_ready = 1'b1;

   // Decode the register index; drop writes to unknown indexes
   always_comb begin
      gains_in = gains_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pica_pkg::CSR_PROP_GAIN:  gains_in.prop_gain  = csr_wdata;
            pica_pkg::CSR_INTEG_GAIN: gains_in.integ_gain = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop_gain  <= pica_pkg::GAIN_RESET;
         gains_ff.integ_gain <= pica_pkg::GAIN_RESET;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign gains = gains_ff;

endmodule

// File: rtl/pica_term.sv
// Input register and the two stages that form the proportional term and the
// integral step (limited error, gain products, divide by ten). Uses pica_pkg.
`timescale 1ns / 1ps

module pica_term (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pica_pkg::req_type    req_data,
   input  pica_pkg::gain_type   gains,
   input  logic                 term_ready,
   output logic                 term_valid,
   output pica_pkg::term_type   term
);

   // Stage valids
   logic in_v_ff, in_v_in;
   logic s1_v_ff, s1_v_in;
   logic s2_v_ff, s2_v_in;
   logic adv_in, adv_s1, adv_s2;

   // Payload registers
   pica_pkg::req_type                in_data_ff;
   logic                             s1_sign_ff, s1_sign_in;
   logic [pica_pkg::P_MAG_W-1:0]     s1_p_mag_ff, s1_p_mag_in;
   logic [pica_pkg::I_MAG_W-1:0]     s1_i_mag_ff, s1_i_mag_in;
   pica_pkg::term_type               s2_term_ff, s2_term_in;

   // Stage 1 helpers
   logic signed [pica_pkg::LEVEL_W:0] diff;
   logic [pica_pkg::LEVEL_W:0]        diff_abs;
   logic [pica_pkg::ERR_W-1:0]        err_mag;
   logic [pica_pkg::GAIN_W+1:0]       integ_gain3;

   // Stage 2 helpers
   logic [31:0]                       p_prod;
   logic [31:0]                       i_prod;
   logic [pica_pkg::P_TERM_W-1:0]     p_quo;
   logic [pica_pkg::I_TERM_W-1:0]     i_quo;

   // Each stage moves when the one after it is empty or moving
   assign adv_s2    = !s2_v_ff || term_ready;
   assign adv_s1    = !s1_v_ff || adv_s2;
   assign adv_in    = !in_v_ff || adv_s1;
   assign req_stall = !adv_in;

   assign in_v_in = adv_in ? req_valid : in_v_ff;
   assign s1_v_in = adv_s1 ? in_v_ff   : s1_v_ff;
   assign s2_v_in = adv_s2 ? s1_v_ff   : s2_v_ff;

   // Stage 1: limit the error to +-50, split into sign and magnitude, multiply
   always_comb begin
      diff = $signed({1'b0, in_data_ff.target_level})
           - $signed({1'b0, in_data_ff.measured_level});
      diff_abs = diff[pica_pkg::LEVEL_W] ? (~diff + 1'b1) : diff;
      s1_sign_in = diff[pica_pkg::LEVEL_W];
      if (diff_abs > {{(pica_pkg::LEVEL_W+1-pica_pkg::ERR_W){1'b0}}, pica_pkg::ERR_LIMIT}) begin
         err_mag = pica_pkg::ERR_LIMIT;
      end else begin
         err_mag = diff_abs[pica_pkg::ERR_W-1:0];
      end
      integ_gain3 = {2'b00, gains.integ_gain} + {1'b0, gains.integ_gain, 1'b0};
      s1_p_mag_in = pica_pkg::P_MAG_W'(err_mag * gains.prop_gain);
      s1_i_mag_in = pica_pkg::I_MAG_W'(err_mag * integ_gain3);
   end

   // Stage 2: divide magnitudes by ten, then restore the sign (truncates to zero)
   always_comb begin
      p_prod = 32'(s1_p_mag_ff) * 32'(pica_pkg::DIV10_RECIP);
      i_prod = 32'(s1_i_mag_ff) * 32'(pica_pkg::DIV10_RECIP);
      p_quo  = pica_pkg::P_TERM_W'(p_prod >> pica_pkg::DIV10_SHIFT);
      i_quo  = pica_pkg::I_TERM_W'(i_prod >> pica_pkg::DIV10_SHIFT);
      s2_term_in.p_term = s1_sign_ff ? $signed(~p_quo + 1'b1) : $signed(p_quo);
      s2_term_in.i_step = s1_sign_ff ? $signed(~i_quo + 1'b1) : $signed(i_quo);
   end

   // Valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   // Payload: load only when the stage advances
   always_ff @(posedge clock) begin
      if (adv_in) begin
         in_data_ff <= req_data;
      end
      if (adv_s1) begin
         s1_sign_ff  <= s1_sign_in;
         s1_p_mag_ff <= s1_p_mag_in;
         s1_i_mag_ff <= s1_i_mag_in;
      end
      if (adv_s2) begin
         s2_term_ff <= s2_term_in;
      end
   end

   assign term_valid = s2_v_ff;
   assign term       = s2_term_ff;

endmodule

// File: rtl/pica_integ.sv
// Accumulator, output clamp with back-calculation, and the result register.
// Uses pica_pkg.
`timescale 1ns / 1ps

module pica_integ (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 term_valid,
   input  pica_pkg::term_type   term,
   output logic                 term_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pica_pkg::rsp_type    rsp_data
);

   localparam int SUM_W = pica_pkg::ACC_W + 1;
   localparam logic signed [SUM_W-1:0] SUM_MAX =
      $signed({{(SUM_W-pica_pkg::DRIVE_W){1'b0}}, pica_pkg::OUT_MAX});

   logic                          rsp_v_ff, rsp_v_in;
   pica_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic [pica_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic                          load;

   logic signed [SUM_W-1:0] acc_x, p_x, i_x, integ_sum, ctrl_sum;
   logic [pica_pkg::DRIVE_W-1:0] ctrl_out;

   // Result register frees up when empty or when its beat is taken
   assign term_ready = !rsp_v_ff || !rsp_stall;
   assign load       = term_valid && term_ready;
   assign rsp_v_in   = term_ready ? term_valid : rsp_v_ff;

   // Add the accumulator, clamp to 0..100, back-calculate on a clamp
   always_comb begin
      acc_x = $signed({acc_ff[pica_pkg::ACC_W-1], acc_ff});
      p_x   = SUM_W'(term.p_term);
      i_x   = SUM_W'(term.i_step);
      integ_sum = acc_x + i_x;
      ctrl_sum  = p_x + integ_sum;
      acc_in    = acc_ff;
      if (ctrl_sum > SUM_MAX) begin
         ctrl_out            = pica_pkg::OUT_MAX;
         rsp_data_in.limited = 1'b1;
         if (load) acc_in = pica_pkg::ACC_W'(SUM_MAX - p_x);
      end else if (ctrl_sum < 0) begin
         ctrl_out            = '0;
         rsp_data_in.limited = 1'b1;
         if (load) acc_in = pica_pkg::ACC_W'(-p_x);
      end else begin
         ctrl_out            = ctrl_sum[pica_pkg::DRIVE_W-1:0];
         rsp_data_in.limited = 1'b0;
         if (load) acc_in = integ_sum[pica_pkg::ACC_W-1:0];
      end
      rsp_data_in.drive_level = pica_pkg::OUT_MAX - ctrl_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
         acc_ff   <= pica_pkg::ACC_RESET;
      end else begin
         rsp_v_ff <= rsp_v_in;
         acc_ff   <= acc_in;
      end
   end

   // Hold the result while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/pi_controller_antiwindup_core.sv
// PI controller with error limiting and integrator anti-windup: top level.
// Instantiates pica_csr, pica_term and pica_integ; uses pica_pkg.
`timescale 1ns / 1ps

// Each req_ beat (target, measured) gives exactly one rsp_ beat (drive_level,
// limited), in order. The path is four registers deep: input register, gain
// products, divide by ten, then the accumulator and clamp into the result
// register. A new request is taken every cycle while rsp_
// keeps up; the rate is set by the accumulator, which does one add, clamp and
// write-back per cycle in the last stage. After reset the gains are 2 and the
// accumulator is 10; write gains through csr_ (index 0 proportional, 1
// integral) only while no item is in flight.

module pi_controller_antiwindup_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pica_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pica_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pica_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pica_pkg::GAIN_W-1:0]     csr_wdata
);

   pica_pkg::gain_type gains;
   pica_pkg::term_type term;
   logic               term_valid;
   logic               term_ready;

   pica_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .gains     (gains)
   );

   pica_term u_term (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .gains      (gains),
      .term_ready (term_ready),
      .term_valid (term_valid),
      .term       (term)
   );

   pica_integ u_integ (
      .clock      (clock),
      .reset      (reset),
      .term_valid (term_valid),
      .term       (term),
      .term_ready (term_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: rtl/pica_checker.sv
// Port-level checks for pi_controller_antiwindup_core, bound to the top level.
// Uses pica_pkg.
`timescale 1ns / 1ps

module pica_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pica_pkg::rsp_type rsp_data
);

   // Drive stays within 0..100
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.drive_level <= pica_pkg::OUT_MAX)
      else $error("drive_level above 100");

   // A clamped result sits at one of the rails
   a_limited_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.limited) |->
         (rsp_data.drive_level == 7'd0 || rsp_data.drive_level == pica_pkg::OUT_MAX))
      else $error("limited result not at a rail");

   // Nothing comes out in the cycle after a reset edge
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind pi_controller_antiwindup_core pica_checker u_pica_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
